// ----- hw/rtl/adpm_pkg.sv -----
// Shared types and constants for the arcade drive pulse mixer.
package adpm_pkg;

   localparam logic [14:0] DEADZONE_RESET = 15'd3276;
   localparam logic [6:0]  GAIN_RESET     = 7'd35;
   localparam logic [6:0]  GAIN_FULL      = 7'd100;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 15;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEADZONE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN     = 2'd1;

   localparam logic [10:0] PULSE_NEUTRAL = 11'd1500;
   localparam logic [10:0] PULSE_FWD_MIN = 11'd1525;
   localparam logic [10:0] PULSE_FWD_MAX = 11'd2000;
   localparam logic [10:0] PULSE_REV_MIN = 11'd1000;
   localparam logic [11:0] PULSE_MIRROR  = 12'd3000;

   localparam logic [7:0]  FLIP_TOP      = 8'd255;
   localparam logic [23:0] AXIS_ROUND    = 24'd32767;
   localparam int unsigned AXIS_SHIFT    = 15;

   // floor(v/100) for v below 25600: (v * 5243) >> 19
   localparam logic [12:0] RECIP_HUNDRED = 13'd5243;
   localparam int unsigned HUNDRED_SHIFT = 19;

   // floor(t*475/254) for t up to 254: (t * 62749875) >> 25
   localparam logic [25:0] MAP_GAIN  = 26'd62749875;
   localparam int unsigned MAP_SHIFT = 25;

   typedef struct packed {
      logic signed [15:0] stick_x;
      logic signed [15:0] stick_y;
      logic               slow_button;
   } req_type;

   typedef struct packed {
      logic [10:0] front_left_pulse;
      logic [10:0] front_right_pulse;
      logic [10:0] back_left_pulse;
      logic [10:0] back_right_pulse;
      logic        all_neutral;
   } rsp_type;

   typedef struct packed {
      logic signed [8:0] left;
      logic signed [8:0] right;
      logic [6:0]        gain;
   } mix_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
   } stage_en_type;

endpackage

// ----- hw/rtl/adpm_mix.sv -----
// Deadzone, axis scaling, arcade mix and gain selection (stages one and two).
module adpm_mix import adpm_pkg::*; (
   input  logic         clock,
   input  stage_en_type ctl,
   input  req_type      req_data,
   input  logic [14:0]  deadzone,
   input  logic [6:0]   gain_cfg,
   output mix_type      mix
);

   logic signed [16:0] xe, ye, ax, ay;
   logic               in_dz;
   logic signed [15:0] xs, ys;
   logic signed [23:0] xw, yw;
   logic signed [23:0] px_in, py_in, px_ff, py_ff;
   logic               slow_in, slow_ff;

   logic signed [23:0] rx, ry;
   logic signed [8:0]  sx, sy;
   logic signed [9:0]  sum, dif, hsum, hdif;
   mix_type            mix_in, mix_ff;

   always_comb begin
      xe = {req_data.stick_x[15], req_data.stick_x};
      ye = {req_data.stick_y[15], req_data.stick_y};
      ax = xe[16] ? -xe : xe;
      ay = ye[16] ? -ye : ye;
      in_dz = ($unsigned(ax) <= {2'b00, deadzone}) && ($unsigned(ay) <= {2'b00, deadzone});
      xs = in_dz ? 16'sd0 : req_data.stick_x;
      ys = in_dz ? 16'sd0 : req_data.stick_y;
      xw = {{8{xs[15]}}, xs};
      yw = {{8{ys[15]}}, ys};
      px_in = (xw <<< 8) - xw;
      py_in = (yw <<< 8) - yw;
      slow_in = req_data.slow_button;
   end

   always_ff @(posedge clock) begin
      if (ctl.s1) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         slow_ff <= slow_in;
      end
   end

   always_comb begin
      rx = px_ff[23] ? px_ff + $signed(AXIS_ROUND) : px_ff;
      ry = py_ff[23] ? py_ff + $signed(AXIS_ROUND) : py_ff;
      sx = 9'(rx >>> AXIS_SHIFT);
      sy = 9'(ry >>> AXIS_SHIFT);
      sum = {sy[8], sy} + {sx[8], sx};
      dif = {sy[8], sy} - {sx[8], sx};
      hsum = (sum + {9'd0, sum[9]}) >>> 1;
      hdif = (dif + {9'd0, dif[9]}) >>> 1;
      mix_in.left  = hsum[8:0];
      mix_in.right = hdif[8:0];
      if (!slow_ff) begin
         mix_in.gain = GAIN_FULL;
      end else if (gain_cfg > GAIN_FULL) begin
         mix_in.gain = GAIN_FULL;
      end else begin
         mix_in.gain = gain_cfg;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s2) begin
         mix_ff <= mix_in;
      end
   end

   assign mix = mix_ff;

endmodule

// ----- hw/rtl/adpm_pulse.sv -----
// Gain, divide by one hundred and pulse mapping of one drive side (stages three to five).
module adpm_pulse import adpm_pkg::*; (
   input  logic              clock,
   input  stage_en_type      ctl,
   input  logic signed [8:0] value,
   input  logic [6:0]        gain,
   output logic [10:0]       pulse
);

   logic [8:0]  mag9;
   logic [14:0] prod_in, prod_ff;
   logic        neg3_in, neg3_ff;

   logic [27:0] qp;
   logic [7:0]  q;
   logic [7:0]  t_in, t_ff;
   logic        neg4_ff, zero_in, zero4_ff;

   logic [33:0] m_in, m_ff;
   logic        neg5_ff, zero5_ff;
   logic [10:0] off;

   always_comb begin
      neg3_in = value[8];
      mag9    = neg3_in ? 9'(-value) : 9'(value);
      prod_in = 15'({7'd0, mag9[7:0]} * {8'd0, gain});
   end

   always_ff @(posedge clock) begin
      if (ctl.s3) begin
         prod_ff <= prod_in;
         neg3_ff <= neg3_in;
      end
   end

   always_comb begin
      qp      = 28'(prod_ff) * 28'(RECIP_HUNDRED);
      q       = qp[HUNDRED_SHIFT+7:HUNDRED_SHIFT];
      zero_in = (q == 8'd0);
      t_in    = neg3_ff ? FLIP_TOP - q : q - 8'd1;
   end

   always_ff @(posedge clock) begin
      if (ctl.s4) begin
         t_ff     <= t_in;
         neg4_ff  <= neg3_ff;
         zero4_ff <= zero_in;
      end
   end

   assign m_in = 34'(t_ff) * 34'(MAP_GAIN);

   always_ff @(posedge clock) begin
      if (ctl.s5) begin
         m_ff     <= m_in;
         neg5_ff  <= neg4_ff;
         zero5_ff <= zero4_ff;
      end
   end

   always_comb begin
      off = {2'b00, m_ff[MAP_SHIFT+8:MAP_SHIFT]};
      if (zero5_ff) begin
         pulse = PULSE_NEUTRAL;
      end else if (neg5_ff) begin
         pulse = PULSE_REV_MIN + off;
      end else begin
         pulse = PULSE_FWD_MIN + off;
      end
   end

endmodule

// ----- hw/rtl/arcade_drive_pulse_mixer_core.sv -----
// Top level of the arcade drive pulse mixer: handshake, configuration and output stage.
//
// Each joystick sample runs through a six-stage pipeline (deadzone and scale,
// mix, gain, divide by one hundred, pulse multiply, output register) and its
// four pulse widths leave from the output register. One sample is taken every
// cycle while req_stall is low; rsp_stall holds the output register and the
// stages behind it fill in turn, and req_stall rises only when every stage holds a sample.
// Configuration writes are always ready and take effect on following samples.
module arcade_drive_pulse_mixer_core import adpm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   logic [14:0]  deadzone_ff, deadzone_in;
   logic [6:0]   gain_ff, gain_in;
   logic [6:1]   valid_ff, valid_in;
   logic [6:1]   adv;
   stage_en_type ctl;
   mix_type      mix;
   logic [10:0]  pulse_left, pulse_right, pr;
   logic [11:0]  pr_wide;
   rsp_type      rsp_in, rsp_ff;

   assign csr_ready = 1'b1;

   always_comb begin
      deadzone_in = deadzone_ff;
      gain_in     = gain_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEADZONE: deadzone_in = csr_data[14:0];
            CSR_GAIN:     gain_in     = csr_data[6:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff <= DEADZONE_RESET;
         gain_ff     <= GAIN_RESET;
      end else begin
         deadzone_ff <= deadzone_in;
         gain_ff     <= gain_in;
      end
   end

   always_comb begin
      adv[6] = !valid_ff[6] || !rsp_stall;
      for (int k = 5; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[1] = adv[1] ? req_valid : valid_ff[1];
      for (int k = 2; k <= 6; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
      ctl.s1 = adv[1];
      ctl.s2 = adv[2];
      ctl.s3 = adv[3];
      ctl.s4 = adv[4];
      ctl.s5 = adv[5];
      ctl.s6 = adv[6];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !adv[1];

   adpm_mix u_mix (
      .clock    (clock),
      .ctl      (ctl),
      .req_data (req_data),
      .deadzone (deadzone_ff),
      .gain_cfg (gain_ff),
      .mix      (mix)
   );

   adpm_pulse u_left (
      .clock (clock),
      .ctl   (ctl),
      .value (mix.left),
      .gain  (mix.gain),
      .pulse (pulse_left)
   );

   adpm_pulse u_right (
      .clock (clock),
      .ctl   (ctl),
      .value (mix.right),
      .gain  (mix.gain),
      .pulse (pulse_right)
   );

   always_comb begin
      pr_wide = PULSE_MIRROR - {1'b0, pulse_right};
      pr      = pr_wide[10:0];
      rsp_in.front_left_pulse  = pulse_left;
      rsp_in.front_right_pulse = pr;
      rsp_in.back_left_pulse   = pulse_left;
      rsp_in.back_right_pulse  = pr;
      rsp_in.all_neutral       = (pulse_left == PULSE_NEUTRAL) && (pr == PULSE_NEUTRAL);
   end

   always_ff @(posedge clock) begin
      if (ctl.s6) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff[6];
   assign rsp_data  = rsp_ff;

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (valid_ff == 6'b111111))
      else $error("input stalled with a free pipeline stage");

   a_neutral_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.all_neutral ==
         ((rsp_data.front_left_pulse == PULSE_NEUTRAL) &&
          (rsp_data.front_right_pulse == PULSE_NEUTRAL))))
      else $error("neutral flag disagrees with pulses");

   a_left_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.front_left_pulse >= PULSE_REV_MIN) &&
                    (rsp_data.front_left_pulse <= PULSE_FWD_MAX))
      else $error("left pulse out of range");

   a_right_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.front_right_pulse >= PULSE_REV_MIN) &&
                    (rsp_data.front_right_pulse <= PULSE_FWD_MAX))
      else $error("right pulse out of range");

endmodule
